[rtl/lmi_pkg.sv]
// ----------------------------------------------------------------------------
// lmi_pkg: shared types and constants of the linear move interpolator
// Payload structs, status codes and arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none
package lmi_pkg;

  localparam int unsigned MaxStepsDefault = 65535;
  localparam logic [15:0] FullSpeedReset = 16'd5120;
  localparam logic [14:0] PercentQ8 = 15'd25600;

  typedef enum logic [1:0] {
    STATUS_MOVE  = 2'd0,
    STATUS_POINT = 2'd1,
    STATUS_IDLE  = 2'd2,
    STATUS_ZERO  = 2'd3
  } status_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [14:0]        speed_percent;
  } lmi_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0]        step_total;
    logic               last_point;
  } lmi_out_t;

  // Request to and answer from the shared restoring divider.
  typedef struct packed {
    logic        start;
    logic [66:0] dividend;
    logic [66:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [66:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

[rtl/lmi_div.sv]
// ----------------------------------------------------------------------------
// lmi_div: shared unsigned restoring divider
// One quotient bit per cycle over 67 steps.
// ----------------------------------------------------------------------------
`default_nettype none
module lmi_div
  import lmi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [66:0] quo;
  logic [66:0] rem;
  logic [66:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [67:0] trial;

  always_comb begin
    trial = {rem, quo[66]} - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= 7'd67;
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        if (!trial[67]) begin
          rem <= trial[66:0];
          quo <= {quo[65:0], 1'b1};
        end else begin
          rem <= {rem[65:0], quo[66]};
          quo <= {quo[65:0], 1'b0};
        end
        cnt  <= cnt - 7'd1;
        done <= (cnt == 7'd1);
        if (cnt == 7'd1) busy <= 1'b0;
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp = {done, quo};

endmodule
`default_nettype wire

[rtl/linear_move_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// linear_move_interpolator_unit: straight-line three-axis move generator
// Plans a step count from the move distance and speed, then emits points.
// ----------------------------------------------------------------------------
// channel   direction  handshake         payload
// in        input      in_valid/in_stall  lmi_in_t
// out       output     out_valid/out_stall lmi_out_t
// cfg       input      cfg_we             full_speed_step
//
// A tick or a rejected move goes from acceptance through S_OUT, which registers its result.
// A planned move computes three squares and a 34-step square root, then the
// count division and three increment divisions on one bit-serial divider of
// 67 steps, with one 34x34 multiplier reused for every product. A zero step
// size skips the count division.
// Reset is synchronous and leaves the block idle at the origin.
// A stalled result holds the block; no new transaction is taken until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_move_interpolator_unit
  import lmi_pkg::*;
#(
  parameter int unsigned MAX_STEPS = MaxStepsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire lmi_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output lmi_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIFF  = 10'b0000000010,
    S_SQ    = 10'b0000000100,
    S_ROOT  = 10'b0000001000,
    S_DEN   = 10'b0000010000,
    S_NUM   = 10'b0000100000,
    S_CNT   = 10'b0001000000,
    S_INC   = 10'b0010000000,
    S_INCW  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  logic [15:0] full_speed_step;
  lmi_in_t     item;
  logic signed [31:0] cur [3];
  logic signed [31:0] inc [3];
  logic [15:0] steps_remaining;
  logic signed [32:0] diff [3];
  logic [1:0]  axis;
  logic [67:0] sumsq;
  logic [33:0] root;
  logic [5:0]  bitpos;
  logic [15:0] count;
  logic [1:0]  res_status;
  logic [15:0] res_total;
  logic        res_last;

  // Shared multiplier with a registered product.
  logic [33:0] mul_a, mul_b;
  logic [67:0] prod;

  div_req_t dreq;
  div_rsp_t drsp;

  lmi_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [33:0] cand;
  logic [32:0] absd;
  logic [66:0] qsel;
  logic signed [33:0] qsgn;

  always_comb begin
    cand  = root | (34'd1 << bitpos);
    absd  = diff[axis][32] ? -diff[axis] : diff[axis];
    mul_a = {1'b0, absd};
    mul_b = {1'b0, absd};
    unique case (state)
      S_ROOT: begin mul_a = cand; mul_b = cand; end
      S_DEN: begin
        mul_a = {19'd0, item.speed_percent};
        mul_b = {18'd0, full_speed_step};
      end
      S_NUM: begin mul_a = root; mul_b = {19'd0, PercentQ8}; end
      default: ;
    endcase
    qsel = drsp.quotient;
    qsgn = (qsel[66:33] != '0) ? 34'sh1_FFFF_FFFF : {1'b0, qsel[32:0]};
    if (diff[axis][32]) qsgn = -qsgn;
  end

  logic [1:0] phase;
  logic signed [33:0] sum3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) sum3[i] = 34'(cur[i]) + 34'(inc[i]);
  end

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      full_speed_step <= FullSpeedReset;
      steps_remaining <= '0;
      dreq.start      <= 1'b0;
      for (int i = 0; i < 3; i++) begin cur[i] <= '0; inc[i] <= '0; end
    end else begin
      if (cfg_we) full_speed_step <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          item <= in_data;
          res_total <= '0;
          if (in_data.mode) begin
            if (steps_remaining == '0) begin
              res_status <= STATUS_IDLE;
              res_last   <= 1'b0;
            end else begin
              for (int i = 0; i < 3; i++) cur[i] <= sat32(sum3[i]);
              steps_remaining <= steps_remaining - 16'd1;
              res_status <= STATUS_POINT;
              res_last   <= (steps_remaining == 16'd1);
            end
            state <= S_OUT;
          end else if (in_data.speed_percent == '0) begin
            res_status <= STATUS_ZERO;
            res_last   <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff[0] <= 33'(item.target_x) - 33'(item.start_x);
          diff[1] <= 33'(item.target_y) - 33'(item.start_y);
          diff[2] <= 33'(item.target_z) - 33'(item.start_z);
          axis  <= 2'd0;
          phase <= 2'd0;
          sumsq <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          // One cycle issues a square, the next accumulates it.
          if (phase == 2'd0) begin
            phase <= 2'd1;
          end else begin
            phase <= 2'd0;
            sumsq <= sumsq + prod;
            if (axis == 2'd2) begin
              root <= '0; bitpos <= 6'd33; state <= S_ROOT;
            end else begin
              axis <= axis + 2'd1;
            end
          end
        end
        S_ROOT: begin
          if (phase == 2'd0) begin
            phase <= 2'd1;
          end else begin
            phase <= 2'd0;
            if (prod <= sumsq) root <= cand;
            if (bitpos == '0) state <= S_DEN;
            else bitpos <= bitpos - 6'd1;
          end
        end
        S_DEN: begin
          if (phase == 2'd0) phase <= 2'd1;
          else begin
            phase <= 2'd0;
            dreq.divisor <= {36'd0, prod[30:0]};
            state <= S_NUM;
          end
        end
        S_NUM: begin
          if (phase == 2'd0) phase <= 2'd1;
          else begin
            phase <= 2'd0;
            if (dreq.divisor == '0) begin
              count <= 16'(MAX_STEPS);
              axis <= 2'd0;
              state <= S_INC;
            end else begin
              dreq.dividend <= prod[66:0];
              dreq.start <= 1'b1;
              state <= S_CNT;
            end
          end
        end
        S_CNT: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            if (qsel == '0) count <= 16'd1;
            else if (qsel > 67'(MAX_STEPS)) count <= 16'(MAX_STEPS);
            else count <= qsel[15:0];
            axis <= 2'd0;
            state <= S_INC;
          end
        end
        S_INC: begin
          dreq.dividend <= {34'd0, absd};
          dreq.divisor  <= {51'd0, count};
          dreq.start    <= 1'b1;
          state <= S_INCW;
        end
        S_INCW: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            inc[axis] <= sat32(qsgn);
            if (axis == 2'd2) begin
              cur[0] <= item.start_x; cur[1] <= item.start_y; cur[2] <= item.start_z;
              steps_remaining <= count;
              res_status <= STATUS_MOVE;
              res_total  <= count;
              res_last   <= 1'b0;
              state <= S_OUT;
            end else begin
              axis <= axis + 2'd1;
              state <= S_INC;
            end
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_data = {res_status, cur[0], cur[1], cur[2], res_total, res_last};

endmodule
`default_nettype wire

[rtl/lmi_checker.sv]
// ----------------------------------------------------------------------------
// lmi_checker: port-level checks of the linear move interpolator
// Watches the handshakes and the result codes on the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module lmi_checker
  import lmi_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire lmi_out_t out_data
);

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Only a point carries the last-point mark.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_point |-> out_data.status == STATUS_POINT)
    else $error("last mark on a non-point result");

  // A planned move never reports zero steps.
  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_MOVE |-> out_data.step_total != '0)
    else $error("move with zero steps");

  // An accepted transaction blocks the input on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open while busy");

endmodule

bind linear_move_interpolator_unit lmi_checker u_lmi_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

[bench/linear_move_interpolator_unit_test.sv]
// ----------------------------------------------------------------------------
// linear_move_interpolator_unit_test: self-checking bench of the interpolator
// Drives moves and ticks with random idling on both channels, predicts every
// result with its own fixed-point move planner and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_move_interpolator_unit_test;
  import lmi_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  lmi_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lmi_out_t out_data;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  linear_move_interpolator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  localparam int unsigned StepLimit = 65535;
  localparam longint unsigned CycleLimit = 2000000;

  // Planner state mirrored from the block.
  logic [15:0] step_size;
  longint pos_x, pos_y, pos_z, inc_x, inc_y, inc_z;
  longint unsigned steps_left;

  lmi_in_t pending_items[$];
  lmi_out_t expected_points[$];
  bit failed = 1'b0;
  bit quiet = 1'b0;
  longint unsigned cycle_count = 0;
  int in_gap = 0;
  int out_gap = 0;

  // Stall value seen at the last rising edge, so the driver knows what was taken.
  logic in_stall_seen = 1'b1;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Floor square root of a sum of three squares, below 2^68.
  function automatic logic [67:0] root_of(logic [69:0] s);
    logic [69:0] r;
    logic [69:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (70'd1 << b);
      if (c * c <= s) r = c;
    end
    return r[67:0];
  endfunction

  function automatic lmi_out_t plan_item(lmi_in_t it);
    lmi_out_t o;
    longint dx, dy, dz;
    logic [69:0] sum;
    logic [69:0] root_len, num, den, count;
    o = '0;
    if (it.mode == 1'b0) begin
      if (it.speed_percent == 0) begin
        o.status = STATUS_ZERO;
      end else begin
        dx = longint'(it.target_x) - longint'(it.start_x);
        dy = longint'(it.target_y) - longint'(it.start_y);
        dz = longint'(it.target_z) - longint'(it.start_z);
        sum = 70'(dx < 0 ? -dx : dx) * 70'(dx < 0 ? -dx : dx)
            + 70'(dy < 0 ? -dy : dy) * 70'(dy < 0 ? -dy : dy)
            + 70'(dz < 0 ? -dz : dz) * 70'(dz < 0 ? -dz : dz);
        root_len = 70'(root_of(sum));
        num = root_len * 70'd25600;
        den = 70'(it.speed_percent) * 70'(step_size);
        count = (den == 0) ? 70'(StepLimit) : num / den;
        if (count == 0) count = 70'd1;
        if (count > 70'(StepLimit)) count = 70'(StepLimit);
        inc_x = clamp32(dx / longint'(count));
        inc_y = clamp32(dy / longint'(count));
        inc_z = clamp32(dz / longint'(count));
        pos_x = it.start_x; pos_y = it.start_y; pos_z = it.start_z;
        steps_left = 64'(count);
        o.status = STATUS_MOVE;
        o.step_total = count[15:0];
      end
    end else if (steps_left == 0) begin
      o.status = STATUS_IDLE;
    end else begin
      pos_x = clamp32(pos_x + inc_x);
      pos_y = clamp32(pos_y + inc_y);
      pos_z = clamp32(pos_z + inc_z);
      steps_left--;
      o.status = STATUS_POINT;
      o.last_point = (steps_left == 0);
    end
    o.point_x = pos_x[31:0];
    o.point_y = pos_y[31:0];
    o.point_z = pos_z[31:0];
    return o;
  endfunction

  function automatic void queue_item(lmi_in_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic logic [31:0] any_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 4000)) - 32'd2000;
      default: return $urandom;
    endcase
  endfunction

  function automatic lmi_in_t make_move(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                        logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                                        logic [14:0] spd);
    lmi_in_t it;
    it = '0;
    it.mode = 1'b0;
    it.start_x = sx; it.start_y = sy; it.start_z = sz;
    it.target_x = tx; it.target_y = ty; it.target_z = tz;
    it.speed_percent = spd;
    return it;
  endfunction

  function automatic lmi_in_t make_tick();
    lmi_in_t it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[207:0];
    it.mode = 1'b1;
    return it;
  endfunction

  // Short move near a random base so that the planned count stays small.
  function automatic lmi_in_t short_move(int unsigned span);
    logic [31:0] bx, by, bz;
    bx = any_coord(); by = any_coord(); bz = any_coord();
    return make_move(bx, by, bz,
                     bx + 32'($urandom_range(0, span)) - 32'(span / 2),
                     by + 32'($urandom_range(0, span)) - 32'(span / 2),
                     bz + 32'($urandom_range(0, span)) - 32'(span / 2),
                     15'($urandom_range(1, 32767)));
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_points.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_step(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    step_size = v;
  endtask

  // Driver: presents the head of the pending queue, idling in bursts.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_seen) begin
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall_seen) begin
        // Hold the stalled transaction.
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 && (quiet || $urandom_range(0, 7) != 0)) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
        if (!quiet) in_gap <= $urandom_range(1, 5);
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predicts on accepted inputs and checks accepted results.
  always @(posedge clk) begin
    lmi_out_t exp_o;
    cycle_count <= cycle_count + 1;
    in_stall_seen <= rst ? 1'b1 : in_stall;
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_points.insert(expected_points.size(), plan_item(in_data));
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_data);
          failed = 1'b1;
        end else begin
          exp_o = expected_points.pop_front();
          if (exp_o.status != out_data.status)
            $display("%0t: status expected %0d actual %0d", $time, exp_o.status,
                     out_data.status);
          if (exp_o.point_x != out_data.point_x)
            $display("%0t: point_x expected %0d actual %0d", $time, exp_o.point_x,
                     out_data.point_x);
          if (exp_o.point_y != out_data.point_y)
            $display("%0t: point_y expected %0d actual %0d", $time, exp_o.point_y,
                     out_data.point_y);
          if (exp_o.point_z != out_data.point_z)
            $display("%0t: point_z expected %0d actual %0d", $time, exp_o.point_z,
                     out_data.point_z);
          if (exp_o.step_total != out_data.step_total)
            $display("%0t: step_total expected %0d actual %0d", $time, exp_o.step_total,
                     out_data.step_total);
          if (exp_o.last_point != out_data.last_point)
            $display("%0t: last_point expected %0d actual %0d", $time, exp_o.last_point,
                     out_data.last_point);
          if (exp_o != out_data) failed = 1'b1;
        end
      end
      if (cycle_count > CycleLimit) begin
        $display("linear_move_interpolator_unit_test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    bit held;
    step_size = FullSpeedReset;
    pos_x = 0; pos_y = 0; pos_z = 0;
    inc_x = 0; inc_y = 0; inc_z = 0;
    steps_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: idle tick, zero speed, extremes, overflow, short moves.
    queue_item(make_tick());
    queue_item(make_move(0, 0, 0, 32'd10240, 0, 0, 15'd0));
    queue_item(make_move(0, 0, 0, 32'd10240, 32'd0, 32'd0, 15'd25600));
    repeat (3) queue_item(make_tick());
    queue_item(make_move(32'h7FFF_FFF0, 32'h8000_0010, 32'd5,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 15'h7FFF));
    repeat (2) queue_item(make_tick());
    queue_item(make_move(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 15'd1));
    queue_item(make_tick());
    queue_item(make_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 15'h7FFF));
    queue_item(make_move(32'd7, 32'd7, 32'd7, 32'd7, 32'd7, 32'd7, 15'd100));
    repeat (2) queue_item(make_tick());
    queue_item(make_move(32'd100, 32'd200, 32'd300, 32'd0, 32'd0, 32'd0, 15'd0));
    queue_item(make_tick());
    wait_drained();

    // Zero step size saturates the count; the largest step size is tried with short moves.
    write_step(16'd0);
    queue_item(make_move(32'd0, 32'd0, 32'd0, 32'd65535, 32'd0, 32'd0, 15'd25600));
    repeat (3) queue_item(make_tick());
    wait_drained();
    write_step(16'hFFFF);
    queue_item(short_move(1 << 20));
    repeat (2) queue_item(make_tick());
    wait_drained();
    write_step(16'd1);
    queue_item(short_move(64));
    wait_drained();

    // Random phases over several step sizes.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_step(FullSpeedReset);
        1: write_step(16'd1024);
        2: write_step(16'($urandom_range(1, 65535)));
        3: write_step(16'hFFFF);
        default: write_step(16'd4096);
      endcase
      quiet = (phase == 4);
      n = 0;
      held = 1'b0;
      while (n < 100) begin
        case ($urandom_range(0, 9))
          0: queue_item(make_move(any_coord(), any_coord(), any_coord(),
                                  any_coord(), any_coord(), any_coord(),
                                  15'($urandom)));
          1: queue_item(make_tick());
          2: queue_item(make_move(any_coord(), any_coord(), any_coord(),
                                  any_coord(), any_coord(), any_coord(), 15'd0));
          default: begin
            queue_item(short_move(40000));
            repeat ($urandom_range(1, 8)) begin
              queue_item(make_tick());
              n++;
            end
          end
        endcase
        n++;
        if (n >= 50 && phase == 1 && !held) begin
          // Sender holds off until the block has answered everything.
          held = 1'b1;
          while (pending_items.size() != 0 || expected_points.size() != 0) @(posedge clk);
        end
      end
      wait_drained();
    end

    if (!failed) begin
      $display("linear_move_interpolator_unit_test passed");
    end else begin
      $display("linear_move_interpolator_unit_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
